>>> rtl/evad_pkg.sv
package evad_pkg;

    // sample and arithmetic widths
    localparam int SAMPLE_BITS = 16;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_BITS = 43;

    // frame length handling
    localparam int MAX_FRAME   = 8192;
    localparam int LEN_BITS    = 14;
    localparam int CNT_BITS    = $clog2(MAX_FRAME + 1);
    localparam int HANG_BITS   = 8;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 43;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENERGY_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HANGOVER_FRAMES  = 2'd2;

    localparam logic [CNT_BITS-1:0]    RST_FRAME_LENGTH     = CNT_BITS'(4096);
    localparam logic [ENERGY_BITS-1:0] RST_ENERGY_THRESHOLD = 43'd3958241859;
    localparam logic [HANG_BITS-1:0]   RST_HANGOVER_FRAMES  = 8'd4;

    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = {ENERGY_BITS{1'b1}};
    localparam logic [HANG_BITS-1:0]   QUIET_MAX  = {HANG_BITS{1'b1}};

    typedef struct packed {
        logic [CNT_BITS-1:0]    frame_len;   // already clamped to 1..MAX_FRAME
        logic [ENERGY_BITS-1:0] threshold;
        logic [HANG_BITS-1:0]   hangover;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [SQ_BITS-1:0] square;
    } t_sq_stage;

endpackage

>>> rtl/evad_if.sv
interface evad_sample_if
    import evad_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface evad_result_if
    import evad_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   speaking;
    logic                   utterance_start;
    logic                   utterance_end;
    logic [ENERGY_BITS-1:0] frame_energy;

    modport source (output valid, output speaking, output utterance_start,
                    output utterance_end, output frame_energy, input ready);
    modport sink   (input valid, input speaking, input utterance_start,
                    input utterance_end, input frame_energy, output ready);
endinterface

interface evad_cfg_if
    import evad_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/evad_cfg_regs.sv
module evad_cfg_regs
    import evad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    evad_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    logic [LEN_BITS-1:0] w_len;
    logic [CNT_BITS-1:0] w_len_eff;
    t_cfg                r_cfg;

    assign i_cfg.ready = 1'b1;
    assign w_len       = i_cfg.data[LEN_BITS-1:0];

    // zero acts as one, anything past the max frame clamps
    always_comb begin
        if (w_len == '0) begin
            w_len_eff = CNT_BITS'(1);
        end else if (32'(w_len) > MAX_FRAME) begin
            w_len_eff = CNT_BITS'(MAX_FRAME);
        end else begin
            w_len_eff = CNT_BITS'(w_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_len <= RST_FRAME_LENGTH;
            r_cfg.threshold <= RST_ENERGY_THRESHOLD;
            r_cfg.hangover  <= RST_HANGOVER_FRAMES;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_LENGTH:     r_cfg.frame_len <= w_len_eff;
                CFG_ENERGY_THRESHOLD: r_cfg.threshold <= i_cfg.data[ENERGY_BITS-1:0];
                CFG_HANGOVER_FRAMES:  r_cfg.hangover  <= i_cfg.data[HANG_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/evad_square.sv
module evad_square
    import evad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    evad_sample_if.sink i_sample,
    input  logic        i_stall,
    output t_sq_stage   o_sq
);

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic                          w_s1_load;
    logic [MAG_BITS-1:0]           w_mag;
    logic [2*MAG_BITS-1:0]         w_prod;
    logic                          r_s2_valid;
    logic [SQ_BITS-1:0]            r_s2_square;

    // input stage may fill while the rest holds, as long as it is empty
    assign w_s1_load      = !i_stall || !r_s1_valid;
    assign i_sample.ready = w_s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_sample.valid) begin
            r_s1_sample <= i_sample.sample;
        end
    end

    // magnitude, one bit wider so the most negative sample fits
    always_comb begin
        if (r_s1_sample[SAMPLE_BITS-1]) begin
            w_mag = MAG_BITS'(-{r_s1_sample[SAMPLE_BITS-1], r_s1_sample});
        end else begin
            w_mag = {1'b0, r_s1_sample};
        end
    end

    assign w_prod = w_mag * w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!i_stall) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall && r_s1_valid) begin
            r_s2_square <= w_prod[SQ_BITS-1:0];
        end
    end

    assign o_sq = '{valid: r_s2_valid, square: r_s2_square};

endmodule

>>> rtl/evad_frame.sv
module evad_frame
    import evad_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_sq_stage     i_sq,
    output logic          o_stall,
    evad_result_if.source o_result
);

    typedef enum logic {
        ST_SILENCE,
        ST_SPEAKING
    } t_vad_state;

    t_vad_state             r_state, n_state;
    logic [ENERGY_BITS-1:0] r_acc;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [HANG_BITS-1:0]   r_quiet, n_quiet;

    logic                   r_out_valid;
    logic                   r_out_speaking;
    logic                   r_out_start;
    logic                   r_out_end;
    logic [ENERGY_BITS-1:0] r_out_energy;

    logic [ENERGY_BITS:0]   w_sum;
    logic [ENERGY_BITS-1:0] w_energy;
    logic [CNT_BITS-1:0]    w_cnt_inc;
    logic                   w_frame_end;
    logic                   w_go;
    logic                   w_start, w_end;
    logic [HANG_BITS-1:0]   w_quiet_inc;

    assign w_sum    = {1'b0, r_acc} + (ENERGY_BITS + 1)'(i_sq.square);
    assign w_energy = w_sum[ENERGY_BITS] ? ENERGY_MAX : w_sum[ENERGY_BITS-1:0];

    // a shortened frame ends as soon as the count catches up
    assign w_cnt_inc   = r_cnt + CNT_BITS'(1);
    assign w_frame_end = i_sq.valid && (w_cnt_inc >= i_cfg.frame_len);

    // only a frame end needs the output register
    assign o_stall = w_frame_end && r_out_valid && !o_result.ready;
    assign w_go    = i_sq.valid && !o_stall;

    assign w_quiet_inc = (r_quiet < QUIET_MAX) ? r_quiet + HANG_BITS'(1) : r_quiet;

    always_comb begin
        n_state = r_state;
        n_quiet = r_quiet;
        w_start = 1'b0;
        w_end   = 1'b0;
        unique case (r_state)
            ST_SILENCE: begin
                if (w_energy > i_cfg.threshold) begin
                    n_state = ST_SPEAKING;
                    n_quiet = '0;
                    w_start = 1'b1;
                end
            end
            ST_SPEAKING: begin
                if (w_energy < i_cfg.threshold) begin
                    // zero hangover falls out as one here
                    if (w_quiet_inc >= i_cfg.hangover) begin
                        n_state = ST_SILENCE;
                        n_quiet = '0;
                        w_end   = 1'b1;
                    end else begin
                        n_quiet = w_quiet_inc;
                    end
                end else begin
                    n_quiet = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_SILENCE;
            r_acc          <= '0;
            r_cnt          <= '0;
            r_quiet        <= '0;
            r_out_valid    <= 1'b0;
            r_out_speaking <= 1'b0;
            r_out_start    <= 1'b0;
            r_out_end      <= 1'b0;
            r_out_energy   <= '0;
        end else begin
            if (w_go) begin
                if (w_frame_end) begin
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= n_state;
                    r_quiet <= n_quiet;
                end else begin
                    r_acc <= w_energy;
                    r_cnt <= w_cnt_inc;
                end
            end
            if (w_go && w_frame_end) begin
                r_out_valid    <= 1'b1;
                r_out_speaking <= (n_state == ST_SPEAKING);
                r_out_start    <= w_start;
                r_out_end      <= w_end;
                r_out_energy   <= w_energy;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.speaking        = r_out_speaking;
    assign o_result.utterance_start = r_out_start;
    assign o_result.utterance_end   = r_out_end;
    assign o_result.frame_energy    = r_out_energy;

endmodule

>>> rtl/energy_voice_activity_detector.sv
// Energy voice activity detector: one Q15 sample per transaction, one result per frame.
// A frame's last sample passes the input register, the square register and the result register.
// Throughput: 1 sample per cycle while not stalled, set by the square register and the accumulate stage.
// Input only stalls when a frame end meets an output result that has not been taken.
// Reset (i_rst_n low at a clock edge, synchronous): pipeline empty, accumulator,
// sample count and quiet count zero, state silence, registers at their defaults.
module energy_voice_activity_detector
    import evad_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    evad_cfg_if.sink      i_cfg,
    evad_sample_if.sink   i_sample,
    evad_result_if.source o_result
);

    t_cfg      w_cfg;     // clamped register view
    t_sq_stage w_sq;      // squared sample, registered
    logic      w_stall;   // frame end blocked by a waiting result

    // register file; frame length is clamped on write
    evad_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // input register, magnitude and square
    evad_square u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_stall  (w_stall),
        .o_sq     (w_sq)
    );

    // saturating accumulate, frame count, silence/speaking machine, result register
    evad_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_sq     (w_sq),
        .o_stall  (w_stall),
        .o_result (o_result)
    );

endmodule
